@@ design/sha_pkg.sv @@
// Shared types and constants of the SHA-512/384 hash core.
// Holds the round constants and initial values; used by sha_round and the top level.
package sha_pkg;

  localparam int WordW = 64;

  typedef logic [WordW-1:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int RoundCount = 80;

  function automatic word_t round_const(input logic [6:0] idx);
    word_t k;
    k = '0;
    unique case (idx)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_value(input logic mode, input logic [2:0] idx);
    word_t v;
    v = '0;
    unique case ({mode, idx})
      4'd0: v = 64'h6a09e667f3bcc908; 4'd1: v = 64'hbb67ae8584caa73b;
      4'd2: v = 64'h3c6ef372fe94f82b; 4'd3: v = 64'ha54ff53a5f1d36f1;
      4'd4: v = 64'h510e527fade682d1; 4'd5: v = 64'h9b05688c2b3e6c1f;
      4'd6: v = 64'h1f83d9abfb41bd6b; 4'd7: v = 64'h5be0cd19137e2179;
      4'd8: v = 64'hcbbb9d5dc1059ed8; 4'd9: v = 64'h629a292a367cd507;
      4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
      4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
      4'd14: v = 64'hdb0c2e0d64f98fa7; 4'd15: v = 64'h47b5481dbefa4fa4;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

@@ design/sha_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/sha_round.sv @@
// One SHA-512 round, purely combinational.
// Depends on sha_pkg.
module sha_round
  import sha_pkg::*;
(
  input  word_t       v_in [8],
  input  word_t       k_in,
  input  word_t       w_in,
  output word_t       v_out [8]
);
  word_t t1;
  word_t t2;

  always_comb begin
    t1 = v_in[7] + (ror(v_in[4], 14) ^ ror(v_in[4], 18) ^ ror(v_in[4], 41))
       + ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6])) + k_in + w_in;
    t2 = (ror(v_in[0], 28) ^ ror(v_in[0], 34) ^ ror(v_in[0], 39))
       + ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end
endmodule

@@ design/sha512_sha384_hash_core_top.sv @@
// SHA-512 / SHA-384 hash core. A full 64-bit word beat is written into the
// block memory; the 16th word starts the compression: the schedule window is
// loaded from the block memory, then the chaining value, then 80 rounds run
// at one per cycle and the working variables are added back into the
// chaining memory. A last beat adds the padding words, possibly one more
// compression, then 8 or 6 digest beats, each held until out_tready takes
// it, and then the initial value is reloaded. The input is not ready during
// any of this. Block words and chaining value live in synchronous RAMs; the
// schedule window is held in registers.
module sha512_sha384_hash_core_top
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // digest_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,       // data_word[63:0], byte_count[67:64], zero
  input  logic        in_tlast,       // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,      // digest_word
  output logic [2:0]  out_tuser,      // word_index
  output logic        out_tlast       // last_result
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PAD, S_CRD, S_CLD, S_RND, S_UPD_RD, S_UPD_WR,
    S_OUT_RD, S_OUT
  } state_t;

  // Padding phase: the 0x80 word is still owed, zeros are owed with the length
  // in this block, zeros are owed but the length goes into the next block, or
  // padding is complete.
  typedef enum logic [1:0] {
    PAD_DONE, PAD_MARK, PAD_ZERO, PAD_SPILL
  } pad_t;

  state_t      state_r;
  logic        mode_r;
  logic [63:0] msg_bytes_r;
  logic [3:0]  slot_r;
  pad_t        pad_slot_r;      // padding word source selector
  logic        finishing_r;
  logic [2:0]  cnt8_r;
  logic [6:0]  rnd_r;
  word_t       v_r [8];
  word_t       w_win_r [16];
  word_t       ch_rdata, bk_rdata, ch_wdata, bk_wdata;
  logic        ch_we, bk_we;
  logic [2:0]  ch_waddr, ch_raddr;
  logic [3:0]  bk_waddr, bk_raddr;
  word_t       v_next [8];
  word_t       w_cur;
  word_t       sched;
  logic [3:0]  cnt_sat;
  word_t       pad_word;
  logic [63:0] tot_bytes;
  logic [2:0]  nwords;

  sha_ram #(.Width(64), .Depth(8)) u_chain (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata));

  sha_ram #(.Width(64), .Depth(16)) u_block (
    .clk, .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata));

  // The block words are copied into a 16-deep shift window during the load.
  always_comb begin
    sched = (ror(w_win_r[14], 19) ^ ror(w_win_r[14], 61) ^ (w_win_r[14] >> 6))
          + w_win_r[9]
          + (ror(w_win_r[1], 1) ^ ror(w_win_r[1], 8) ^ (w_win_r[1] >> 7))
          + w_win_r[0];
    w_cur = (rnd_r < 7'd16) ? w_win_r[rnd_r[3:0]] : sched;
  end

  sha_round u_round (.v_in(v_r), .k_in(round_const(rnd_r)), .w_in(w_cur),
                     .v_out(v_next));

  assign cnt_sat   = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
  assign tot_bytes = msg_bytes_r + (in_tlast ? {60'd0, cnt_sat} : 64'd8);
  assign nwords    = mode_r ? 3'd5 : 3'd7;

  // Padding words after the data: the lone 0x80 word, then zeros, with the
  // length in slot 15 of the block that has room for it.
  always_comb begin
    if (pad_slot_r == PAD_MARK) pad_word = {PadByte, 56'd0};
    else if (slot_r == 4'd15 && pad_slot_r == PAD_ZERO)
      pad_word = {msg_bytes_r[60:0], 3'b000};
    else pad_word = '0;
  end

  function automatic word_t last_word_fmt(input word_t d, input logic [3:0] c);
    word_t m;
    m = (c == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (8 * c));
    return (d & m) | ({56'd0, PadByte} << (56 - 8 * c));
  endfunction

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    ch_we = 1'b0; ch_waddr = cnt8_r; ch_wdata = init_value(mode_r, cnt8_r);
    ch_raddr = cnt8_r;
    bk_we = 1'b0; bk_waddr = slot_r; bk_wdata = in_tdata[63:0];
    bk_raddr = rnd_r[3:0];
    unique case (state_r)
      S_INIT: ch_we = 1'b1;
      S_IDLE: begin
        bk_we = in_tvalid;
        if (in_tlast && cnt_sat != 4'd8) bk_wdata = last_word_fmt(in_tdata[63:0], cnt_sat);
      end
      S_PAD: begin bk_we = 1'b1; bk_wdata = pad_word; end
      S_UPD_WR: begin
        ch_we = 1'b1; ch_wdata = ch_rdata + v_r[cnt8_r];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; mode_r <= 1'b0; msg_bytes_r <= '0; slot_r <= '0;
      cnt8_r <= '0; rnd_r <= '0; finishing_r <= 1'b0; pad_slot_r <= PAD_DONE;
      out_tvalid <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata; state_r <= S_INIT; cnt8_r <= '0;
      msg_bytes_r <= '0; slot_r <= '0; finishing_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          cnt8_r <= cnt8_r + 3'd1;
          if (cnt8_r == 3'd7) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          msg_bytes_r <= tot_bytes;
          slot_r <= slot_r + 4'd1;
          rnd_r <= '0;
          if (in_tlast) begin
            finishing_r <= 1'b1;
            if (cnt_sat == 4'd8) pad_slot_r <= PAD_MARK;
            else if (slot_r >= 4'd14) pad_slot_r <= PAD_SPILL;
            else pad_slot_r <= PAD_ZERO;
          end
          if (slot_r == 4'd15) state_r <= S_CLD;
          else if (in_tlast) state_r <= S_PAD;
        end
        S_PAD: begin
          slot_r <= slot_r + 4'd1;
          rnd_r <= '0;
          // A block that has no room for the length is compressed first.
          if (pad_slot_r == PAD_MARK)
            pad_slot_r <= (slot_r >= 4'd14) ? PAD_SPILL : PAD_ZERO;
          else if (pad_slot_r == PAD_ZERO && slot_r == 4'd15)
            pad_slot_r <= PAD_DONE;
          if (slot_r == 4'd15) state_r <= S_CLD;
        end
        S_CLD: begin
          // rnd_r walks the block read address; data returns next cycle.
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r != '0) w_win_r[rnd_r[3:0] - 4'd1] <= bk_rdata;
          if (rnd_r == 7'd16) begin
            state_r <= S_CRD; cnt8_r <= '0; rnd_r <= '0;
          end
        end
        S_CRD: begin
          // chain read pipelined: address cnt8_r, the registered read data is stored at cnt8_r - 1.
          cnt8_r <= cnt8_r + 3'd1;
          if (rnd_r[0]) v_r[cnt8_r - 3'd1] <= ch_rdata;
          rnd_r <= {6'd0, 1'b1};
          if (rnd_r[0] && cnt8_r == 3'd0) begin
            state_r <= S_RND; rnd_r <= '0;
          end
        end
        S_RND: begin
          v_r <= v_next;
          if (rnd_r >= 7'd16) begin
            for (int i = 0; i < 15; i++) w_win_r[i] <= w_win_r[i + 1];
            w_win_r[15] <= sched;
          end else if (rnd_r == 7'd15) begin
            // window already holds w0..w15 in order
          end
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'(RoundCount - 1)) begin
            state_r <= S_UPD_RD; cnt8_r <= '0;
          end
        end
        S_UPD_RD: state_r <= S_UPD_WR;
        S_UPD_WR: begin
          cnt8_r <= cnt8_r + 3'd1;
          state_r <= S_UPD_RD;
          if (cnt8_r == 3'd7) begin
            slot_r <= '0; rnd_r <= '0;
            if (!finishing_r) state_r <= S_IDLE;
            else if (pad_slot_r == PAD_DONE) begin
              state_r <= S_OUT_RD; cnt8_r <= '0;
            end else begin
              state_r <= S_PAD;
              if (pad_slot_r == PAD_SPILL) pad_slot_r <= PAD_ZERO;
            end
          end
        end
        S_OUT_RD: state_r <= S_OUT;
        S_OUT: begin
          if (!out_tvalid) begin
            out_tvalid <= 1'b1; out_tdata <= ch_rdata; out_tuser <= cnt8_r;
            out_tlast <= (cnt8_r == nwords);
          end else if (out_tready) begin
            out_tvalid <= 1'b0;
            cnt8_r <= cnt8_r + 3'd1;
            if (cnt8_r == nwords) begin
              state_r <= S_INIT; cnt8_r <= '0; msg_bytes_r <= '0;
              finishing_r <= 1'b0; slot_r <= '0;
            end else state_r <= S_OUT_RD;
          end
        end
        default: state_r <= S_INIT;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == S_OUT)) else $error("digest beat outside output");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) |-> (rnd_r < 7'd80)) else $error("round counter overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == 3'd5 || out_tuser == 3'd7))
    else $error("bad final digest index");
endmodule

@@ tb/tb_sha512_sha384_hash_core_top.sv @@
// Self-checking testbench for the SHA-512/384 hash core.
// It holds its own hash predictor and declares its own port widths to match the top level.
// It needs sha512_sha384_hash_core_top with sha_pkg, sha_ram and sha_round.
module tb_sha512_sha384_hash_core_top;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } msg_beat_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  msg_beat_t    pending_beats[$];
  digest_beat_t digest_expect[$];
  msg_beat_t    beat_on_bus;
  int           in_gap = 0;
  int           out_gap = 0;
  int           stall_cycles = 0;
  int           error_count = 0;
  int           items_queued = 0;
  bit           quiet = 1'b0;

  // Predictor state.
  logic        hash_mode = 1'b0;
  logic [63:0] chain[8];
  logic [63:0] blk[16];
  int          slot;
  logic [63:0] msg_bytes;

  logic [63:0] rc [0:79] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // SHA-512 initial value in entries 0..7, SHA-384 in 8..15.
  logic [63:0] iv_tab [0:15] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179,
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  sha512_sha384_hash_core_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = iv_tab[{hash_mode, 3'(i)}];
    msg_bytes = '0;
    slot = 0;
  endtask

  task automatic compress_block();
    logic [63:0] w[16];
    logic [63:0] v[8];
    logic [63:0] wr, t1, t2, a2, a15;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        a2 = w[(r - 2) & 15];
        a15 = w[(r - 15) & 15];
        wr = (rotr(a2, 19) ^ rotr(a2, 61) ^ (a2 >> 6)) + w[(r - 7) & 15]
           + (rotr(a15, 1) ^ rotr(a15, 8) ^ (a15 >> 7)) + w[r & 15];
        w[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rc[r] + wr;
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic absorb_word(input logic [63:0] w);
    blk[slot] = w;
    slot++;
    if (slot == 16) begin
      compress_block();
      slot = 0;
    end
  endtask

  // Folds one accepted beat into the running hash; a closing beat pads the
  // message and queues the digest words.
  task automatic hash_beat(input msg_beat_t b);
    int c;
    int n;
    logic [63:0] mask;
    digest_beat_t d;
    c = (b.cnt > 8) ? 8 : int'(b.cnt);
    if (!b.last) begin
      msg_bytes += 64'd8;
      absorb_word(b.data);
    end else begin
      msg_bytes += 64'(c);
      if (c == 8) begin
        absorb_word(b.data);
        absorb_word(64'h8000000000000000);
      end else begin
        mask = (c == 0) ? '0 : (~64'd0 << (64 - 8 * c));
        absorb_word((b.data & mask) | (64'h80 << (56 - 8 * c)));
      end
      while (slot != 14) absorb_word('0);
      absorb_word('0);
      absorb_word(msg_bytes << 3);
      n = hash_mode ? 6 : 8;
      for (int i = 0; i < n; i++) begin
        d.word = chain[i];
        d.idx = 3'(i);
        d.last = (i == n - 1);
        digest_expect.push_back(d);
      end
      restart_message();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic queue_beat(input logic [63:0] data, input logic [3:0] cnt,
                            input logic last);
    msg_beat_t b;
    b.data = data;
    b.cnt = cnt;
    b.last = last;
    pending_beats.push_back(b);
    items_queued++;
  endtask

  task automatic queue_random_message(input int words);
    for (int i = 0; i < words; i++)
      queue_beat({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
    queue_beat({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
  endtask

  task automatic queue_random_messages(input int budget);
    int stop_at;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 7) == 0) queue_random_message($urandom_range(16, 40));
      else queue_random_message($urandom_range(0, 17));
    end
  endtask

  // Waits until every beat is out and every digest word is back, then lets
  // the core finish any compression it still has in flight.
  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || digest_expect.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    hash_mode = m;
    restart_message();
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) hash_beat(beat_on_bus);
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(0, 5);
            in_tvalid <= 1'b0;
          end else begin
            beat_on_bus = pending_beats.pop_front();
            in_tdata <= {4'b0, beat_on_bus.cnt, beat_on_bus.data};
            in_tlast <= beat_on_bus.last;
            in_tvalid <= 1'b1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor, receiver back-pressure and watchdog.
  always @(posedge clk) begin
    digest_beat_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (digest_expect.size() == 0) begin
          report_mismatch("unexpected digest beat", out_tdata, '0);
        end else begin
          e = digest_expect.pop_front();
          if (out_tdata !== e.word) report_mismatch("digest_word", out_tdata, e.word);
          if (out_tuser !== e.idx) report_mismatch("word_index", 64'(out_tuser), 64'(e.idx));
          if (out_tlast !== e.last) report_mismatch("last_result", 64'(out_tlast), 64'(e.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    restart_message();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part in SHA-512 mode.
    queue_beat(64'hffffffffffffffff, 4'd0, 1'b1);   // empty message
    queue_beat(64'hffffffffffffffff, 4'd1, 1'b1);
    queue_beat(64'hffffffffffffffff, 4'd15, 1'b1);  // count above eight
    queue_beat(64'h0123456789abcdef, 4'd3, 1'b0);   // short count on a middle word
    queue_beat(64'hfedcba9876543210, 4'd7, 1'b1);
    queue_beat(64'h0000000000000000, 4'd8, 1'b1);
    // Fourteen full words and a full closing word: padding spills into a new block.
    for (int i = 0; i < 14; i++) queue_beat({$urandom, $urandom}, 4'd8, 1'b0);
    queue_beat(64'h8000000000000001, 4'd8, 1'b1);
    // A partial message that the mode write below abandons.
    for (int i = 0; i < 3; i++) queue_beat({$urandom, $urandom}, 4'd8, 1'b0);
    drain();
    write_mode(1'b1);

    queue_beat(64'hffffffffffffffff, 4'd0, 1'b1);
    queue_random_messages(150);
    drain();
    write_mode(1'b0);

    queue_random_messages(150);
    for (int i = 0; i < 20; i++) queue_beat({$urandom, $urandom}, 4'd8, 1'b0);
    drain();
    write_mode(1'b1);

    quiet = 1'b1;
    queue_random_messages(160);
    drain();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
